/* hdl/flic_pkg.sv */
// Package for the FLIC pixel chunk decoder: phase and mode codes, frame limits.
// No dependencies.
package flic_pkg;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  typedef enum logic [3:0] {
    P_IDLE, P_DONE, P_HDR, P_LINE, P_OPHI, P_SKIP, P_COUNT,
    P_VALUE, P_VALUE2, P_LIT, P_COPY
  } phase_e;

  localparam logic [2:0] M_BRUN  = 3'd0;
  localparam logic [2:0] M_FLI   = 3'd1;
  localparam logic [2:0] M_FLC   = 3'd2;
  localparam logic [2:0] M_BLACK = 3'd3;
  localparam logic [2:0] M_COPY  = 3'd4;

  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_FILL = 2'd1;
  localparam logic [1:0] WK_PAIR = 2'd2;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] addr;
    logic [20:0] len;
    logic [7:0]  fill;
    logic [7:0]  pair;
  } wr_t;

  typedef struct packed {
    wr_t        w0;
    wr_t        w1;
    logic       two;
    logic       done;
    logic       err;
  } res_t;
endpackage

/* hdl/flic_core.sv */
// Decoder state machine: one body byte per call, produces up to two writes.
// Depends on flic_pkg.
module flic_core import flic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        chunk_first_i,
  input  logic        chunk_last_i,
  input  logic [10:0] w_i,
  input  logic [10:0] h_i,
  output res_t        res_o
);
  phase_e      phase_q, phase_d;
  logic [16:0] row_q, row_d;
  logic [15:0] col_q, col_d;
  logic [19:0] bl_q, bl_d;
  logic [15:0] pk_q, pk_d;
  logic [15:0] ln_q, ln_d;
  logic [7:0]  hb_q, hb_d;
  logic [8:0]  reb_q, reb_d;
  logic        err_q, err_d;
  logic [2:0]  md_q, md_d;

  always_comb begin
    phase_e      ph;
    logic [16:0] row;
    logic [15:0] col;
    logic [19:0] bl;
    logic [15:0] pk, ln, op, n16;
    logic [7:0]  hb;
    logic [8:0]  reb;
    logic        err, nw, done;
    logic [2:0]  md;
    wr_t         wa, wb;
    logic [7:0]  b;
    logic [7:0]  mag;
    logic [17:0] sum;
    logic [16:0] lim;
    logic [18:0] rtmp;
    logic [31:0] base;
    logic        pkd, le;
    ph = phase_q; row = row_q; col = col_q; bl = bl_q; pk = pk_q; ln = ln_q;
    hb = hb_q; reb = reb_q; err = err_q; md = md_q;
    wa = '0; wb = '0; nw = 1'b0; done = 1'b0; b = data_byte_i;
    mag = '0; sum = '0; lim = '0; rtmp = '0; op = '0; n16 = '0;
    pkd = 1'b0; le = 1'b0;
    if (chunk_first_i) begin
      md = mode_i; row = '0; col = '0; bl = '0; pk = '0; ln = '0;
      hb = '0; reb = '0; err = 1'b0;
      case (mode_i)
        M_BRUN:  ph = (h_i == 11'd0) ? P_DONE : P_LINE;
        M_FLI, M_FLC: ph = P_HDR;
        M_BLACK: begin
          if (w_i != 0 && h_i != 0) begin
            wa.kind = WK_FILL; wa.len = 21'(w_i) * 21'(h_i); nw = 1'b1;
          end
          ph = P_DONE;
        end
        M_COPY:  ph = (w_i == 0 || h_i == 0) ? P_DONE : P_COPY;
        default: ph = P_DONE;
      endcase
    end
    base = 32'(row) * 32'(w_i);
    if (ph != P_IDLE) begin
      case (ph)
        P_HDR: begin
          if (md == M_FLI) begin
            if (bl == 0 || bl == 2) begin
              hb = b; bl = bl + 20'd1;
            end else if (bl == 1) begin
              row = {1'b0, b, hb}; bl = 20'd2;
            end else begin
              n16 = {b, hb}; bl = '0;
              if (n16[15] || (18'(row) + 18'(n16)) > 18'(h_i)) begin
                err = 1'b1; ph = P_DONE;
              end else begin
                ln = n16; col = '0; ph = (n16 == 0) ? P_DONE : P_LINE;
              end
            end
          end else if (bl == 0) begin
            hb = b; bl = 20'd1;
          end else begin
            bl = '0; ln = {b, hb}; row = '0; col = '0;
            ph = (ln == 0) ? P_DONE : P_LINE;
          end
        end
        P_LINE: begin
          col = '0;
          if (md == M_BRUN) ph = P_COUNT;
          else if (md == M_FLI) begin
            pk = {8'd0, b};
            if (b == 0) le = 1'b1; else ph = P_SKIP;
          end else begin
            hb = b; ph = P_OPHI;
          end
        end
        P_OPHI: begin
          op = {b, hb}; ph = P_LINE;
          case (op[15:14])
            2'b00: begin
              if (row >= 17'(h_i)) begin
                err = 1'b1; ph = P_DONE;
              end else begin
                pk = op; col = '0;
                if (op == 0) le = 1'b1; else ph = P_SKIP;
              end
            end
            2'b10: reb = {1'b1, op[7:0]};
            2'b11: begin
              rtmp = 19'(row) + 19'(17'h10000 - 17'(op));
              row = (rtmp > 19'h1FFFF) ? 17'h1FFFF : rtmp[16:0];
            end
            default: ;
          endcase
        end
        P_SKIP: begin
          sum = 18'(col) + 18'(b);
          col = (sum > 18'hFFFF) ? 16'hFFFF : sum[15:0];
          ph = P_COUNT;
        end
        P_COUNT: begin
          mag = b[7] ? 8'(-b) : b;
          lim = (md == M_FLC && !(b[7] && md == M_BRUN)) ? 17'({mag, 1'b0})
                                                         : 17'(mag);
          if (md == M_FLI && col > 16'(w_i)) begin
            err = 1'b1; ph = P_DONE;
          end else if (18'(col) + 18'(lim) > 18'(w_i)) begin
            err = 1'b1; ph = P_DONE;
          end else if (b[7]) begin
            bl = 20'(mag); ph = (md == M_BRUN) ? P_LIT : P_VALUE;
          end else if (md == M_BRUN) begin
            bl = 20'(mag); ph = P_VALUE;
          end else begin
            bl = 20'(lim);
            if (lim == 0) pkd = 1'b1; else ph = P_LIT;
          end
        end
        P_VALUE: begin
          if (md == M_FLC) begin
            hb = b; ph = P_VALUE2;
          end else begin
            if (bl != 0) begin
              wa.kind = WK_FILL; wa.addr = 20'(base + 32'(col));
              wa.len = 21'(bl); wa.fill = b; nw = 1'b1;
            end
            col = col + 16'(bl); bl = '0;
            if (md == M_BRUN) ph = P_COUNT; else pkd = 1'b1;
          end
        end
        P_VALUE2: begin
          wa.kind = WK_PAIR; wa.addr = 20'(base + 32'(col));
          wa.len = 21'({bl, 1'b0}); wa.fill = hb; wa.pair = b; nw = 1'b1;
          col = col + 16'({bl, 1'b0}); bl = '0; pkd = 1'b1;
        end
        P_LIT: begin
          wa.kind = WK_FILL; wa.addr = 20'(base + 32'(col));
          wa.len = 21'd1; wa.fill = b; nw = 1'b1;
          col = col + 16'd1; bl = bl - 20'd1;
          if (bl == 0) begin
            if (md == M_BRUN) ph = P_COUNT; else pkd = 1'b1;
          end
        end
        P_COPY: begin
          wa.kind = WK_FILL; wa.addr = 20'(base + 32'(col));
          wa.len = 21'd1; wa.fill = b; nw = 1'b1;
          col = col + 16'd1;
          if (col >= 16'(w_i)) begin
            col = '0; row = row + 17'd1;
          end
          if (row >= 17'(h_i)) ph = P_DONE;
        end
        default: ;
      endcase
      // brun row advance after a packet ends at the row's last column
      if (md == M_BRUN && ph == P_COUNT && phase_q != P_LINE
          && !(chunk_first_i)) begin
        if (col >= 16'(w_i)) begin
          col = '0; row = row + 17'd1;
          ph = (row >= 17'(h_i)) ? P_DONE : P_LINE;
        end
      end else if (md == M_BRUN && ph == P_COUNT) begin
        if (col >= 16'(w_i)) begin
          col = '0; row = row + 17'd1;
          ph = (row >= 17'(h_i)) ? P_DONE : P_LINE;
        end
      end
      if (pkd) begin
        pk = pk - 16'd1;
        if (pk == 0) le = 1'b1; else ph = P_SKIP;
      end
      if (le) begin
        if (md == M_FLC && reb[8] && w_i == 0) begin
          err = 1'b1; ph = P_DONE;
        end else begin
          if (md == M_FLC && reb[8]) begin
            wb.kind = WK_FILL; wb.addr = 20'(base + 32'(w_i) - 32'd1);
            wb.len = 21'd1; wb.fill = reb[7:0];
          end
          reb = '0;
          row = (row == 17'h1FFFF) ? row : row + 17'd1;
          col = '0; ln = ln - 16'd1;
          ph = (ln == 0) ? P_DONE : P_LINE;
        end
      end
      if (chunk_last_i) begin
        if (ph != P_DONE) err = 1'b1;
        ph = P_IDLE; done = 1'b1;
      end
    end
    // pack: eol write goes after a data write if both occurred
    res_o.two = 1'b0;
    if (wb.kind != WK_NONE) begin
      if (nw) begin
        res_o.w0 = wa; res_o.w1 = wb; res_o.two = 1'b1;
      end else begin
        res_o.w0 = wb; res_o.w1 = '0;
      end
    end else begin
      res_o.w0 = wa; res_o.w1 = '0;
    end
    res_o.done = done; res_o.err = err;
    phase_d = ph; row_d = row; col_d = col; bl_d = bl; pk_d = pk; ln_d = ln;
    hb_d = hb; reb_d = reb; err_d = err; md_d = md;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE; row_q <= '0; col_q <= '0; bl_q <= '0; pk_q <= '0;
      ln_q <= '0; hb_q <= '0; reb_q <= '0; err_q <= 1'b0; md_q <= M_BRUN;
    end else if (en_i) begin
      phase_q <= phase_d; row_q <= row_d; col_q <= col_d; bl_q <= bl_d;
      pk_q <= pk_d; ln_q <= ln_d; hb_q <= hb_d; reb_q <= reb_d;
      err_q <= err_d; md_q <= md_d;
    end
  end
endmodule

/* hdl/flic_pixel_chunk_decoder.sv */
// FLIC pixel chunk decoder top level: input register, core, two-entry result buffer.
// Depends on flic_pkg and flic_core.
// A request goes through the input register, the core, then the result register.
// Throughput: one byte per cycle while the receiver does not stall; an item with
// two writes holds the next until its second write is taken.
// Reset: asynchronous active low; phase idle, counters clear, width 320, height 200.
module flic_pixel_chunk_decoder import flic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        chunk_first_i,
  input  logic        chunk_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  write_kind_o,
  output logic [19:0] write_address_o,
  output logic [20:0] run_pixels_o,
  output logic [7:0]  fill_value_o,
  output logic [7:0]  pair_value_o,
  output logic        chunk_done_o,
  output logic        chunk_error_o,
  output logic        item_end_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  logic [10:0] fw_q, fh_q, w_eff, h_eff;
  // input register
  logic        iv_q;
  logic [2:0]  md_q;
  logic [7:0]  db_q;
  logic        cf_q, cl_q;
  // result buffer: slot 0 is shown, slot 1 holds the second write
  res_t        res;
  logic        ov_q, pend_q;
  res_t        r_q;
  logic        take_core, in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 11'd320; fh_q <= 11'd200;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) fw_q <= cfg_data_i;
      else fh_q <= cfg_data_i;
    end
  end
  assign w_eff = (fw_q > 11'(MaxWidth)) ? 11'(MaxWidth) : fw_q;
  assign h_eff = (fh_q > 11'(MaxHeight)) ? 11'(MaxHeight) : fh_q;

  // core consumes the input register when the result buffer is free or draining
  assign take_core  = iv_q && (!ov_q || (!out_stall_i && !pend_q));
  assign in_stall_o = iv_q && !take_core;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iv_q <= 1'b0;
    else if (in_acc) iv_q <= 1'b1;
    else if (take_core) iv_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      md_q <= mode_i; db_q <= data_byte_i; cf_q <= chunk_first_i; cl_q <= chunk_last_i;
    end
  end

  flic_core u_core (
    .clk_i, .rst_ni, .en_i(take_core), .mode_i(md_q), .data_byte_i(db_q),
    .chunk_first_i(cf_q), .chunk_last_i(cl_q), .w_i(w_eff), .h_i(h_eff),
    .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; pend_q <= 1'b0;
    end else if (take_core) begin
      ov_q <= 1'b1; pend_q <= res.two;
    end else if (ov_q && !out_stall_i) begin
      if (pend_q) pend_q <= 1'b0; else ov_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (take_core) r_q <= res;
    else if (ov_q && !out_stall_i && pend_q) begin
      r_q.w0 <= r_q.w1; r_q.two <= 1'b0;
    end
  end

  assign out_valid_o     = ov_q;
  assign write_kind_o    = r_q.w0.kind;
  assign write_address_o = r_q.w0.addr;
  assign run_pixels_o    = r_q.w0.len;
  assign fill_value_o    = r_q.w0.fill;
  assign pair_value_o    = r_q.w0.pair;
  assign item_end_o      = !pend_q;
  assign chunk_done_o    = r_q.done && !pend_q;
  assign chunk_error_o   = r_q.err;

  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ov_q) else $error("pending second write without valid");
  a_no_take_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !take_core) else $error("core advanced over a pending write");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(r_q.w0))) else $error("result lost");
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for flic_pixel_chunk_decoder: byte-level predictor, scoreboard, tests.
// Depends on flic_pkg and the decoder RTL.
module tb_top;
  import flic_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        chunk_first_i = 1'b0;
  logic        chunk_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  write_kind_o;
  logic [19:0] write_address_o;
  logic [20:0] run_pixels_o;
  logic [7:0]  fill_value_o;
  logic [7:0]  pair_value_o;
  logic        chunk_done_o;
  logic        chunk_error_o;
  logic        item_end_o;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  flic_pixel_chunk_decoder u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one expected output beat
  typedef struct {
    logic [1:0]  kind;
    logic [19:0] addr;
    logic [20:0] len;
    logic [7:0]  fill;
    logic [7:0]  pair;
    logic        done;
    logic        err;
    logic        iend;
  } beat_t;

  beat_t write_q[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  bit    stall_enable = 1'b1;

  // predictor state
  int unsigned cfg_w = 320, cfg_h = 200;
  phase_e      ph = P_IDLE;
  logic [2:0]  cmode = M_BRUN;
  int unsigned rw, col, left, pkts, lines, held, rowend;
  bit          err_l;
  int unsigned fw, fh;
  beat_t       wr_buf[2];
  int          nwr;

  function automatic void emit_write(int unsigned k, longint unsigned a, int unsigned n,
                                     int unsigned f, int unsigned p);
    if (nwr >= 2) return;
    wr_buf[nwr].kind = k[1:0];
    wr_buf[nwr].addr = a[19:0];
    wr_buf[nwr].len  = n[20:0];
    wr_buf[nwr].fill = f[7:0];
    wr_buf[nwr].pair = p[7:0];
    nwr++;
  endfunction

  function automatic longint unsigned pix_addr();
    return longint'(rw) * fw + col;
  endfunction

  function automatic void abort_chunk();
    err_l = 1'b1;
    ph = P_DONE;
  endfunction

  function automatic void brun_next();
    if (col >= fw) begin
      col = 0;
      rw++;
      ph = (rw >= fh) ? P_DONE : P_LINE;
    end else begin
      ph = P_COUNT;
    end
  endfunction

  function automatic void close_line();
    if (cmode == M_FLC && rowend[8]) begin
      if (fw == 0) begin
        abort_chunk();
        return;
      end
      emit_write(WK_FILL, longint'(rw) * fw + (fw - 1), 1, rowend, 0);
    end
    rowend = 0;
    rw = (rw >= 'h1FFFF) ? 'h1FFFF : rw + 1;
    col = 0;
    lines = (lines - 1) & 'hFFFF;
    ph = (lines == 0) ? P_DONE : P_LINE;
  endfunction

  function automatic void close_packet();
    pkts = (pkts - 1) & 'hFFFF;
    if (pkts == 0) close_line();
    else ph = P_SKIP;
  endfunction

  function automatic void decode_byte(int unsigned b);
    int          sc;
    int unsigned n, op;
    sc = b[7] ? int'(b) - 256 : int'(b);
    case (ph)
      P_HDR: begin
        if (cmode == M_FLI) begin
          if (left == 0 || left == 2) begin
            held = b;
            left++;
          end else if (left == 1) begin
            rw = held | (b << 8);
            left = 2;
          end else begin
            n = held | (b << 8);
            left = 0;
            if (n[15] || rw + n > fh) abort_chunk();
            else begin
              lines = n;
              col = 0;
              ph = (n == 0) ? P_DONE : P_LINE;
            end
          end
        end else if (left == 0) begin
          held = b;
          left = 1;
        end else begin
          left = 0;
          lines = held | (b << 8);
          rw = 0;
          col = 0;
          ph = (lines == 0) ? P_DONE : P_LINE;
        end
      end
      P_LINE: begin
        col = 0;
        if (cmode == M_BRUN) brun_next();
        else if (cmode == M_FLI) begin
          pkts = b;
          if (b == 0) close_line();
          else ph = P_SKIP;
        end else begin
          held = b;
          ph = P_OPHI;
        end
      end
      P_OPHI: begin
        op = held | (b << 8);
        ph = P_LINE;
        case (op >> 14)
          0: begin
            if (rw >= fh) abort_chunk();
            else begin
              pkts = op;
              col = 0;
              if (op == 0) close_line();
              else ph = P_SKIP;
            end
          end
          2: rowend = 'h100 | (op & 'hFF);
          3: begin
            rw = rw + 'h10000 - op;
            if (rw > 'h1FFFF) rw = 'h1FFFF;
          end
          default: ;
        endcase
      end
      P_SKIP: begin
        col += b;
        if (col > 'hFFFF) col = 'hFFFF;
        ph = P_COUNT;
      end
      P_COUNT: begin
        if (cmode == M_FLI && col > fw) abort_chunk();
        else if (sc < 0) begin
          n = -sc;
          if (col + ((cmode == M_FLC) ? 2 * n : n) > fw) abort_chunk();
          else begin
            left = n;
            ph = (cmode == M_BRUN) ? P_LIT : P_VALUE;
          end
        end else begin
          n = sc;
          if (cmode == M_FLC) n *= 2;
          if (col + n > fw) abort_chunk();
          else begin
            left = n;
            if (cmode == M_BRUN) ph = P_VALUE;
            else if (n == 0) close_packet();
            else ph = P_LIT;
          end
        end
      end
      P_VALUE: begin
        if (cmode == M_FLC) begin
          held = b;
          ph = P_VALUE2;
        end else begin
          if (left > 0) emit_write(WK_FILL, pix_addr(), left, b, 0);
          col += left;
          left = 0;
          if (cmode == M_BRUN) brun_next();
          else close_packet();
        end
      end
      P_VALUE2: begin
        emit_write(WK_PAIR, pix_addr(), 2 * left, held, b);
        col += 2 * left;
        left = 0;
        close_packet();
      end
      P_LIT: begin
        emit_write(WK_FILL, pix_addr(), 1, b, 0);
        col++;
        left--;
        if (left == 0) begin
          if (cmode == M_BRUN) brun_next();
          else close_packet();
        end
      end
      P_COPY: begin
        emit_write(WK_FILL, pix_addr(), 1, b, 0);
        col++;
        if (col >= fw) begin
          col = 0;
          rw++;
        end
        if (rw >= fh) ph = P_DONE;
      end
      default: ;
    endcase
  endfunction

  // predict and queue the writes caused by one request
  function automatic void predict_writes(logic [2:0] m, logic [7:0] b, logic f, logic l);
    bit    done;
    int    n;
    beat_t e;
    done = 1'b0;
    fw = (cfg_w > MaxWidth) ? MaxWidth : cfg_w;
    fh = (cfg_h > MaxHeight) ? MaxHeight : cfg_h;
    nwr = 0;
    if (f) begin
      cmode = m;
      rw = 0; col = 0; left = 0; pkts = 0; lines = 0; held = 0; rowend = 0;
      err_l = 1'b0;
      case (m)
        M_BRUN: ph = (fh == 0) ? P_DONE : P_LINE;
        M_FLI, M_FLC: ph = P_HDR;
        M_BLACK: begin
          if (fw * fh > 0) emit_write(WK_FILL, 0, fw * fh, 0, 0);
          ph = P_DONE;
        end
        M_COPY: ph = (fw == 0 || fh == 0) ? P_DONE : P_COPY;
        default: ph = P_DONE;
      endcase
    end
    if (ph != P_IDLE) begin
      decode_byte(b);
      if (l) begin
        if (ph != P_DONE) err_l = 1'b1;
        ph = P_IDLE;
        done = 1'b1;
      end
    end
    n = (nwr > 0) ? nwr : 1;
    for (int k = 0; k < n; k++) begin
      e = '{default: '0};
      if (k < nwr) e = wr_buf[k];
      e.iend = (k == n - 1);
      e.done = e.iend && done;
      e.err  = err_l;
      write_q.push_back(e);
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // send one request; sender gaps are random, valid drops only in a gap
  task automatic send_byte(logic [2:0] m, logic [7:0] b, logic f, logic l);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    data_byte_i   <= b;
    chunk_first_i <= f;
    chunk_last_i  <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_writes(m, b, f, l);
  endtask

  task automatic send_chunk(logic [2:0] m, byte unsigned body[$]);
    foreach (body[i]) send_byte(m, body[i], i == 0, i == body.size() - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (write_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v[10:0];
    @(posedge clk_i);
    if (idx == CFG_WIDTH) cfg_w = v & 'h7FF;
    else cfg_h = v & 'h7FF;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  // receiver stall: random, with stall-free stretches
  always @(posedge clk_i) begin
    if (!stall_enable) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < 25);
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (write_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind=%0d addr=%0d",
                                       write_kind_o, write_address_o);
      end else begin
        e = write_q.pop_front();
        if (e.kind !== write_kind_o || e.addr !== write_address_o ||
            e.len !== run_pixels_o || e.fill !== fill_value_o ||
            e.pair !== pair_value_o || e.done !== chunk_done_o ||
            e.err !== chunk_error_o || e.iend !== item_end_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d a%0d n%0d f%0h p%0h d%0b e%0b l%0b",
                     e.kind, e.addr, e.len, e.fill, e.pair, e.done, e.err, e.iend,
                     " / got k%0d a%0d n%0d f%0h p%0h d%0b e%0b l%0b",
                     write_kind_o, write_address_o, run_pixels_o, fill_value_o,
                     pair_value_o, chunk_done_o, chunk_error_o, item_end_o);
        end
      end
    end
  end

  // watchdog: cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // random well-formed chunk body per mode, occasionally truncated or noisy
  task automatic random_chunk();
    byte unsigned body[$];
    logic [2:0]   m;
    int           nl, np, c;
    m = 3'($urandom_range(0, 6));
    body.push_back(8'($urandom));
    case (m)
      M_BRUN: begin
        body = {};
        nl = $urandom_range(1, 3);
        for (int l = 0; l < nl; l++) begin
          body.push_back(8'($urandom));
          np = $urandom_range(1, 3);
          for (int p = 0; p < np; p++) begin
            c = $urandom_range(0, 4);
            if ($urandom_range(0, 1)) begin
              body.push_back(8'(c));
              body.push_back(8'($urandom));
            end else begin
              body.push_back(8'(-c - 1));
              repeat (c + 1) body.push_back(8'($urandom));
            end
          end
        end
      end
      M_FLI, M_FLC: begin
        body = {};
        nl = $urandom_range(0, 3);
        if (m == M_FLI) begin
          body.push_back(8'($urandom_range(0, 3))); body.push_back(8'h00);
        end
        body.push_back(8'(nl)); body.push_back($urandom_range(0, 9) == 0 ? 8'h80 : 8'h00);
        for (int l = 0; l < nl; l++) begin
          np = $urandom_range(0, 2);
          if (m == M_FLC) begin
            if ($urandom_range(0, 3) == 0) begin
              body.push_back(8'($urandom)); body.push_back(8'h80);
            end
            if ($urandom_range(0, 5) == 0) begin
              body.push_back(8'hFF); body.push_back(8'hFF);
            end
            body.push_back(8'(np)); body.push_back(8'h00);
          end else body.push_back(8'(np));
          for (int p = 0; p < np; p++) begin
            body.push_back(8'($urandom_range(0, 6)));
            c = $urandom_range(0, 3);
            if ($urandom_range(0, 1)) begin
              body.push_back(8'(c));
              repeat ((m == M_FLC) ? 2 * c : c) body.push_back(8'($urandom));
            end else begin
              body.push_back(8'(-c - 1));
              repeat ((m == M_FLC) ? 2 : 1) body.push_back(8'($urandom));
            end
          end
        end
      end
      M_COPY: repeat ($urandom_range(0, 12)) body.push_back(8'($urandom));
      default: repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
    endcase
    // noise: bit flips, truncation or trailing junk
    if ($urandom_range(0, 5) == 0) body[$urandom_range(0, body.size() - 1)] ^= 8'($urandom);
    if ($urandom_range(0, 7) == 0 && body.size() > 1) void'(body.pop_back());
    if ($urandom_range(0, 7) == 0) body.push_back(8'($urandom));
    send_chunk(m, body);
    if ($urandom_range(0, 9) == 0)
      send_byte(3'($urandom), 8'($urandom), 1'b0, 1'($urandom));
  endtask

  task automatic test_black_extremes();
    set_frame(1024, 1024);
    send_chunk(M_BLACK, '{8'hFF});
    set_frame(1, 1);
    send_chunk(M_BLACK, '{8'h00});
    set_frame(0, 5);
    send_chunk(M_BLACK, '{8'h00});
    send_chunk(M_COPY, '{8'h11, 8'h22});
    set_frame(2047, 2047);
    send_chunk(M_BLACK, '{8'h00});
  endtask

  task automatic test_directed_modes();
    set_frame(4, 2);
    send_chunk(M_BRUN, '{8'h00, 8'h04, 8'hAA, 8'h01, 8'hFC, 1, 2, 3, 4, 8'h00});
    send_chunk(M_BRUN, '{8'h00, 8'h05, 8'h55});
    send_chunk(M_COPY, '{8'h01, 8'h02, 8'h03});
    send_chunk(M_FLI, '{8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h01, 8'hFE, 8'h7F});
    send_chunk(M_FLI, '{8'h00, 8'h00, 8'hFF, 8'hFF});
    send_chunk(M_FLC, '{8'h01, 8'h00, 8'h33, 8'h80, 8'hFE, 8'hFF, 8'h01, 8'h00,
                        8'h00, 8'hFF, 8'h12, 8'h34});
    send_chunk(M_FLC, '{8'h01, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00});
    send_chunk(3'd7, '{8'h00, 8'h01});
    send_byte(M_COPY, 8'h9C, 1'b0, 1'b1);
    send_byte(M_COPY, 8'h01, 1'b1, 1'b0);
    send_chunk(M_BRUN, '{8'h00, 8'h02, 8'h0F});
  endtask

  task automatic test_random_chunks();
    int unsigned sizes[4][2] = '{'{1, 1}, '{3, 2}, '{8, 4}, '{1024, 1024}};
    for (int s = 0; s < 4; s++) begin
      set_frame(sizes[s][0], sizes[s][1]);
      for (int i = 0; i < 14; i++) random_chunk();
      // stall-free stretch for the second frame size only, then wait out every expected result
      stall_enable = (s != 1);
      drain();
      stall_enable = 1'b1;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_black_extremes();
    test_directed_modes();
    test_random_chunks();
    drain();
    if (mismatches == 0 && write_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
